@@ design/mirror_symmetry_variant_generator_unit_assert.svh @@
// Assertion macros shared by the mirror symmetry variant generator.
// Depends on nothing; included by the top level only.
`ifndef MIRROR_SYMMETRY_VARIANT_GENERATOR_UNIT_ASSERT_SVH
`define MIRROR_SYMMETRY_VARIANT_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside of reset.
`define MSVG_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside of reset.
`define MSVG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/msvg_pkg.sv @@
// Types and constants of the mirror symmetry variant generator.
// Depends on nothing; used by every module of the block.
package msvg_pkg;

   localparam int CW     = 22;
   localparam int RW     = 23;
   localparam int PW     = 56;
   localparam int NW     = 57;
   localparam int QW     = 21;
   localparam int NUM_DIR = 4;
   localparam int MAX_VAR = 16;

   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_ENABLE   = 3'd2;
   localparam logic [2:0] REG_DIR_0    = 3'd3;
   localparam logic [2:0] REG_DIR_1    = 3'd4;
   localparam logic [2:0] REG_DIR_2    = 3'd5;
   localparam logic [2:0] REG_DIR_3    = 3'd6;

   typedef struct packed {
      logic               op;
      logic signed [15:0] start_x;
      logic signed [15:0] start_y;
      logic signed [15:0] end_x;
      logic signed [15:0] end_y;
      logic [4:0]         limit;
   } req_type;

   typedef struct packed {
      logic signed [15:0] var_start_x;
      logic signed [15:0] var_start_y;
      logic signed [15:0] var_end_x;
      logic signed [15:0] var_end_y;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic       load_item;
      logic       load_subset;
      logic       sq;
      logic       coef;
      logic       mul;
      logic       sum;
      logic       div_start;
      logic       div_write;
      logic       pack;
      logic       rd;
      logic       store;
      logic       pend_load;
      logic       push;
      logic       push_last;
      logic [1:0] refl;
      logic       pt_b;
      logic       axis_y;
      logic [3:0] addr;
   } cmd_type;

   typedef struct packed {
      logic [3:0] usable;
      logic [2:0] n_usable;
      logic [4:0] limit;
      logic       seg;
      logic       div_busy;
      logic       div_done;
      logic       match;
      logic       out_free;
   } sts_type;

   function automatic logic [15:0] sat16(input logic signed [CW-1:0] v);
      logic [15:0] r;
      if (v > CW'(32767)) begin
         r = 16'h7FFF;
      end else if (v < -CW'(32768)) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

@@ design/msvg_div.sv @@
// Iterative rounding divider: round(num / den), one quotient bit per cycle.
// Depends on msvg_pkg.
module msvg_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [msvg_pkg::NW-1:0] num,
   input  logic [31:0]                    den,
   output logic                           busy,
   output logic                           done,
   output logic signed [msvg_pkg::QW:0]   quot
);

   localparam int QW = msvg_pkg::QW;
   localparam int NW = msvg_pkg::NW;

   logic [32:0]    rem_ff;
   logic [QW-1:0]  low_ff;
   logic [32:0]    den2_ff;
   logic           neg_ff;
   logic [4:0]     cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [NW-1:0]  mag;
   logic [NW:0]    dvd;
   logic [33:0]    trial;
   logic           qbit;

   always_comb begin
      mag   = num[NW-1] ? NW'(-num) : NW'(num);
      dvd   = {mag, 1'b0} + (NW + 1)'(den);
      trial = {rem_ff, low_ff[QW-1]};
      qbit  = trial >= {1'b0, den2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(QW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= dvd[QW+32:QW];
         low_ff  <= dvd[QW-1:0];
         den2_ff <= {den, 1'b0};
         neg_ff  <= num[NW-1];
      end else if (busy_ff) begin
         rem_ff <= qbit ? 33'(trial - {1'b0, den2_ff}) : trial[32:0];
         low_ff <= {low_ff[QW-2:0], qbit};
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, low_ff}) : $signed({1'b0, low_ff});

endmodule

@@ design/msvg_datapath.sv @@
// Datapath: configuration registers, coordinate registers, reflection arithmetic,
// variant memory and output register. Depends on msvg_pkg and msvg_div.
module msvg_datapath #(
   parameter int REFLECTORS = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  msvg_pkg::req_type     req_data,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_data,
   input  msvg_pkg::cmd_type     cmd,
   output msvg_pkg::sts_type     sts,
   output logic                  rsp_valid,
   output msvg_pkg::rsp_type     rsp_data,
   input  logic                  rsp_stall
);

   localparam int CW = msvg_pkg::CW;
   localparam int RW = msvg_pkg::RW;
   localparam int PW = msvg_pkg::PW;
   localparam int NW = msvg_pkg::NW;
   localparam int QW = msvg_pkg::QW;

   logic [14:0]               cx_ff;
   logic [14:0]               cy_ff;
   logic [3:0]                en_ff;
   logic [31:0]               dir_ff [msvg_pkg::NUM_DIR];
   logic                      seg_ff;
   logic [4:0]                limit_ff;
   logic signed [CW-1:0]      item_ff [4];
   logic signed [CW-1:0]      w_ff [4];
   logic signed [31:0]        xx_ff;
   logic signed [31:0]        yy_ff;
   logic signed [31:0]        xy_ff;
   logic signed [32:0]        a_ff;
   logic signed [32:0]        b_ff;
   logic [31:0]               l_ff;
   logic signed [PW-1:0]      p_arx_ff;
   logic signed [PW-1:0]      p_bry_ff;
   logic signed [PW-1:0]      p_brx_ff;
   logic signed [PW-1:0]      p_ary_ff;
   logic signed [NW-1:0]      numx_ff;
   logic signed [NW-1:0]      numy_ff;
   logic [63:0]               packed_ff;
   logic [63:0]               rd_ff;
   logic [63:0]               pend_ff;
   logic [63:0]               mem [msvg_pkg::MAX_VAR];
   logic                      rsp_valid_ff;
   msvg_pkg::rsp_type         rsp_ff;
   logic signed [15:0]        dx;
   logic signed [15:0]        dy;
   logic signed [CW-1:0]      px;
   logic signed [CW-1:0]      py;
   logic signed [RW-1:0]      rx;
   logic signed [RW-1:0]      ry;
   logic [3:0]                usable;
   logic                      div_busy;
   logic                      div_done;
   logic signed [QW:0]        quot;
   logic signed [CW-1:0]      ctr;

   always_comb begin
      dx = $signed(dir_ff[cmd.refl][31:16]);
      dy = $signed(dir_ff[cmd.refl][15:0]);
      px = cmd.pt_b ? w_ff[2] : w_ff[0];
      py = cmd.pt_b ? w_ff[3] : w_ff[1];
      rx = RW'(px) - RW'($signed({1'b0, cx_ff}));
      ry = RW'(py) - RW'($signed({1'b0, cy_ff}));
      ctr = cmd.axis_y ? CW'($signed({1'b0, cy_ff})) : CW'($signed({1'b0, cx_ff}));
      for (int i = 0; i < msvg_pkg::NUM_DIR; i++) begin
         usable[i] = (i < REFLECTORS) && en_ff[i] && (dir_ff[i] != 32'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         en_ff     <= '0;
         dir_ff[0] <= 32'h0001_0000;
         dir_ff[1] <= 32'h0000_0001;
         dir_ff[2] <= '0;
         dir_ff[3] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            msvg_pkg::REG_CENTER_X: cx_ff     <= csr_data[14:0];
            msvg_pkg::REG_CENTER_Y: cy_ff     <= csr_data[14:0];
            msvg_pkg::REG_ENABLE:   en_ff     <= csr_data[3:0];
            msvg_pkg::REG_DIR_0:    dir_ff[0] <= csr_data;
            msvg_pkg::REG_DIR_1:    dir_ff[1] <= csr_data;
            msvg_pkg::REG_DIR_2:    dir_ff[2] <= csr_data;
            msvg_pkg::REG_DIR_3:    dir_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         seg_ff     <= req_data.op;
         limit_ff   <= (req_data.limit > 5'd16) ? 5'd16 : req_data.limit;
         item_ff[0] <= CW'(req_data.start_x);
         item_ff[1] <= CW'(req_data.start_y);
         item_ff[2] <= req_data.op ? CW'(req_data.end_x) : '0;
         item_ff[3] <= req_data.op ? CW'(req_data.end_y) : '0;
      end
      if (cmd.load_subset) begin
         w_ff <= item_ff;
      end else if (cmd.div_write) begin
         w_ff[{cmd.pt_b, cmd.axis_y}] <= ctr + CW'(quot);
      end
      if (cmd.sq) begin
         xx_ff <= dx * dx;
         yy_ff <= dy * dy;
         xy_ff <= dx * dy;
      end
      if (cmd.coef) begin
         a_ff <= 33'(xx_ff) - 33'(yy_ff);
         b_ff <= {xy_ff, 1'b0};
         l_ff <= 32'(xx_ff + yy_ff);
      end
      if (cmd.mul) begin
         p_arx_ff <= PW'(a_ff) * PW'(rx);
         p_bry_ff <= PW'(b_ff) * PW'(ry);
         p_brx_ff <= PW'(b_ff) * PW'(rx);
         p_ary_ff <= PW'(a_ff) * PW'(ry);
      end
      if (cmd.sum) begin
         numx_ff <= NW'(p_arx_ff) + NW'(p_bry_ff);
         numy_ff <= NW'(p_brx_ff) - NW'(p_ary_ff);
      end
      if (cmd.pack) begin
         packed_ff <= {msvg_pkg::sat16(w_ff[0]), msvg_pkg::sat16(w_ff[1]),
                       msvg_pkg::sat16(w_ff[2]), msvg_pkg::sat16(w_ff[3])};
      end
      if (cmd.rd) begin
         rd_ff <= mem[cmd.addr];
      end
      if (cmd.store) begin
         mem[cmd.addr] <= packed_ff;
      end
      if (cmd.pend_load) begin
         pend_ff <= packed_ff;
      end
   end

   msvg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (cmd.axis_y ? numy_ff : numx_ff),
      .den   (l_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_ff.var_start_x <= pend_ff[63:48];
         rsp_ff.var_start_y <= pend_ff[47:32];
         rsp_ff.var_end_x   <= pend_ff[31:16];
         rsp_ff.var_end_y   <= pend_ff[15:0];
         rsp_ff.last        <= cmd.push_last;
      end
   end

   always_comb begin
      sts.usable   = usable;
      sts.n_usable = 3'($countones(usable));
      sts.limit    = limit_ff;
      sts.seg      = seg_ff;
      sts.div_busy = div_busy;
      sts.div_done = div_done;
      sts.match    = (rd_ff == packed_ff) ||
                     (seg_ff && (rd_ff == {packed_ff[31:0], packed_ff[63:32]}));
      sts.out_free = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ design/msvg_ctrl.sv @@
// Controller: walks the reflector subsets, sequences each reflection, the
// duplicate scan and the held-back emission. Depends on msvg_pkg.
module msvg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  msvg_pkg::sts_type sts,
   output msvg_pkg::cmd_type cmd,
   output logic              idle
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_SEL   = 11'b000_0000_0010,
      ST_KSEL  = 11'b000_0000_0100,
      ST_COEF  = 11'b000_0000_1000,
      ST_MUL   = 11'b000_0001_0000,
      ST_SUM   = 11'b000_0010_0000,
      ST_DIVS  = 11'b000_0100_0000,
      ST_DIVW  = 11'b000_1000_0000,
      ST_PACK  = 11'b001_0000_0000,
      ST_SCAN  = 11'b010_0000_0000,
      ST_STORE = 11'b100_0000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] size_ff, size_in;
   logic [4:0] p_ff, p_in;
   logic [3:0] cur_ff, cur_in;
   logic [1:0] k_ff, k_in;
   logic       pt_ff, pt_in;
   logic       axis_ff, axis_in;
   logic [3:0] scan_ff, scan_in;
   logic       rd_wait_ff, rd_wait_in;
   logic [4:0] count_ff, count_in;
   logic       pend_ff, pend_in;
   logic       flush_ff, flush_in;

   always_comb begin
      state_in   = state_ff;
      size_in    = size_ff;
      p_in       = p_ff;
      cur_in     = cur_ff;
      k_in       = k_ff;
      pt_in      = pt_ff;
      axis_in    = axis_ff;
      scan_in    = scan_ff;
      rd_wait_in = rd_wait_ff;
      count_in   = count_ff;
      pend_in    = pend_ff;
      flush_in   = flush_ff;
      cmd        = '0;
      cmd.refl   = k_ff;
      cmd.pt_b   = pt_ff;
      cmd.axis_y = axis_ff;
      cmd.addr   = scan_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd.load_item = 1'b1;
               size_in  = '0;
               p_in     = '0;
               count_in = '0;
               pend_in  = 1'b0;
               flush_in = 1'b0;
               state_in = ST_SEL;
            end
         end
         ST_SEL: begin
            if (flush_ff || count_ff >= sts.limit || size_ff > sts.n_usable) begin
               flush_in = 1'b1;
               if (!pend_ff) begin
                  state_in = ST_IDLE;
               end else if (sts.out_free) begin
                  cmd.push      = 1'b1;
                  cmd.push_last = 1'b1;
                  pend_in       = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (p_ff[4]) begin
               size_in = size_ff + 3'd1;
               p_in    = '0;
            end else begin
               p_in = p_ff + 5'd1;
               if (((p_ff[3:0] & ~sts.usable) == 4'd0) &&
                   (3'($countones(p_ff[3:0])) == size_ff)) begin
                  cmd.load_subset = 1'b1;
                  cur_in   = p_ff[3:0];
                  k_in     = '0;
                  state_in = ST_KSEL;
               end
            end
         end
         ST_KSEL: begin
            if (cur_ff[k_ff]) begin
               cmd.sq   = 1'b1;
               state_in = ST_COEF;
            end else if (k_ff == 2'd3) begin
               state_in = ST_PACK;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         ST_COEF: begin
            cmd.coef = 1'b1;
            pt_in    = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            axis_in  = 1'b0;
            state_in = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVW;
         end
         ST_DIVW: begin
            if (sts.div_done) begin
               cmd.div_write = 1'b1;
               if (!axis_ff) begin
                  axis_in  = 1'b1;
                  state_in = ST_DIVS;
               end else if (sts.seg && !pt_ff) begin
                  pt_in    = 1'b1;
                  state_in = ST_MUL;
               end else if (k_ff == 2'd3) begin
                  state_in = ST_PACK;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_KSEL;
               end
            end
         end
         ST_PACK: begin
            cmd.pack   = 1'b1;
            scan_in    = '0;
            rd_wait_in = 1'b0;
            state_in   = (count_ff == 5'd0) ? ST_STORE : ST_SCAN;
         end
         ST_SCAN: begin
            if (!rd_wait_ff) begin
               cmd.rd     = 1'b1;
               rd_wait_in = 1'b1;
            end else begin
               rd_wait_in = 1'b0;
               if (sts.match) begin
                  state_in = ST_SEL;
               end else if (5'(scan_ff) + 5'd1 == count_ff) begin
                  state_in = ST_STORE;
               end else begin
                  scan_in = scan_ff + 4'd1;
               end
            end
         end
         ST_STORE: begin
            cmd.addr = count_ff[3:0];
            if (!pend_ff || sts.out_free) begin
               cmd.store     = 1'b1;
               cmd.push      = pend_ff;
               cmd.pend_load = 1'b1;
               pend_in       = 1'b1;
               count_in      = count_ff + 5'd1;
               state_in      = ST_SEL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         size_ff    <= '0;
         p_ff       <= '0;
         cur_ff     <= '0;
         k_ff       <= '0;
         pt_ff      <= 1'b0;
         axis_ff    <= 1'b0;
         scan_ff    <= '0;
         rd_wait_ff <= 1'b0;
         count_ff   <= '0;
         pend_ff    <= 1'b0;
         flush_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         size_ff    <= size_in;
         p_ff       <= p_in;
         cur_ff     <= cur_in;
         k_ff       <= k_in;
         pt_ff      <= pt_in;
         axis_ff    <= axis_in;
         scan_ff    <= scan_in;
         rd_wait_ff <= rd_wait_in;
         count_ff   <= count_in;
         pend_ff    <= pend_in;
         flush_ff   <= flush_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

@@ design/mirror_symmetry_variant_generator_unit.sv @@
// Top level of the mirror symmetry variant generator.
// Depends on msvg_pkg, msvg_ctrl, msvg_datapath and the assertion header.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data (msvg_pkg::req_type)
//   rsp      out        rsp_valid/rsp_stall  rsp_data (msvg_pkg::rsp_type)
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// One item at a time; each coordinate of a reflected point goes through the shared
// 21-step rounding divider, x first and then y, and a segment reflects both its ends.
// An item walks the masks for each subset size and, per subset, runs its reflections,
// packs the result, scans the variants already stored and stores it if new, waiting
// for the output register when a held-back result must go out.
// Each result is held back one step so that the final one carries last.
// Reset is synchronous; no clearing pass is needed for the variant memory.
// Configuration is taken only while no item is in work.
`include "mirror_symmetry_variant_generator_unit_assert.svh"

module mirror_symmetry_variant_generator_unit #(
   parameter int REFLECTORS = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msvg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msvg_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   msvg_pkg::cmd_type cmd;
   msvg_pkg::sts_type sts;
   logic              idle;
   logic              req_accept;

   assign req_stall  = !idle;
   assign csr_ready  = idle;
   assign req_accept = req_valid && !req_stall;

   msvg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .sts        (sts),
      .cmd        (cmd),
      .idle       (idle)
   );

   msvg_datapath #(
      .REFLECTORS (REFLECTORS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   `MSVG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall, "not busy")
   `MSVG_ASSERT_NOW(a_push_needs_room, clock, reset, cmd.push, sts.out_free, "output overwritten")
   `MSVG_ASSERT_NOW(a_div_not_busy, clock, reset, cmd.div_start, !sts.div_busy, "divider restarted")

endmodule
